>>> sv/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and widths of the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_W = 16;                 // Q8.8 coefficient
    localparam int NB_W   = 25;                 // -b * 256, signed
    localparam int MAG_W  = 34;                 // |b*b - 4ac|
    localparam int RAD_W  = MAG_W + 16;         // radicand scaled by 2^16
    localparam int ROOT_W = RAD_W / 2;          // floor square root
    localparam int REM_W  = ROOT_W + 3;         // square root remainder
    localparam int NUM_W  = 27;                 // numerator nb +/- root, signed
    localparam int DVD_W  = NUM_W - 1 + 7;      // |n| * 128
    localparam int DVS_W  = COEF_W;             // |a|
    localparam int VAL_W  = 32;                 // Q16.16 result
    localparam int QS_W   = DVD_W + 1;          // signed quotient

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_DISTINCT = 2'd0,
        KIND_DOUBLE   = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_DEGEN    = 2'd3
    } kind_t;

    // travels alongside the square root stages
    typedef struct packed {
        kind_t                    kind;
        logic signed [COEF_W-1:0] a;
        logic signed [NB_W-1:0]   nb;
    } sq_side_t;

    // travels alongside the divider stages
    typedef struct packed {
        kind_t             kind;
        logic              neg1;
        logic              neg2;
        logic [DVS_W-1:0]  dvs;
    } dv_side_t;

    typedef struct packed {
        kind_t                   kind;
        logic signed [VAL_W-1:0] v1;
        logic signed [VAL_W-1:0] v2;
        logic                    sat;
    } res_t;

endpackage

>>> sv/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c = 0 from Q8.8 coefficients, Q16.16 results.
// ----------------------------------------------------------------------------
//  channel   dir  signals                   content
//  s_*       in   tvalid tready tdata[47:0] coef_a, coef_b, coef_c
//  m_*       out  tvalid tready tdata[63:0] first_value, second_value
//                 tuser[2:0]                root_kind, saturated
//
//  one equation per cycle while the skid register is empty
//  data passes the 25-stage square root and the 33-stage divider
//  reset clears all valid bits; data registers are not reset
//  a skid register behind the output lets the pipeline keep taking input
//  while a result waits; when the skid fills the whole pipeline holds
// ----------------------------------------------------------------------------
module quadratic_root_solver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // coef_a, coef_b, coef_c
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // first_value, second_value
    output logic [2:0]  m_tuser    // root_kind, saturated
);
    import qrs_pkg::*;

    logic              en;
    logic              fr_valid;
    logic [RAD_W-1:0]  fr_rad;
    sq_side_t          fr_side;
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    sq_side_t          sq_side;

    logic              nm_valid_reg;
    logic [DVD_W-1:0]  dvd1_reg;
    logic [DVD_W-1:0]  dvd2_reg;
    dv_side_t          dside_reg;

    logic signed [NUM_W-1:0] nb_x;
    logic signed [NUM_W-1:0] r_x;
    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
    logic [NUM_W-1:0]        m1;
    logic [NUM_W-1:0]        m2;
    dv_side_t                dside_next;

    logic              dv_valid;
    logic [DVD_W-1:0]  quo1;
    logic [DVD_W-1:0]  quo2;
    dv_side_t          dv_side;

    logic signed [QS_W-1:0] s1;
    logic signed [QS_W-1:0] s2;
    logic                   sat1;
    logic                   sat2;
    res_t                   res_next;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_reg;
    res_t skid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    qrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .a         (s_tdata[15:0]),
        .b         (s_tdata[31:16]),
        .c         (s_tdata[47:32]),
        .out_valid (fr_valid),
        .rad       (fr_rad),
        .side      (fr_side)
    );

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .rad       (fr_rad),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // numerators per root kind
    assign nb_x = NUM_W'(sq_side.nb);
    assign r_x  = NUM_W'(sq_root);

    always_comb
    begin
        case (sq_side.kind)
            KIND_DISTINCT:
            begin
                n1 = nb_x + r_x;
                n2 = nb_x - r_x;
            end
            KIND_COMPLEX:
            begin
                n1 = nb_x;
                n2 = r_x;
            end
            default:
            begin
                n1 = nb_x;
                n2 = nb_x;
            end
        endcase
    end

    assign m1 = n1[NUM_W-1] ? NUM_W'(-n1) : n1;
    assign m2 = n2[NUM_W-1] ? NUM_W'(-n2) : n2;

    always_comb
    begin
        dside_next.kind = sq_side.kind;
        dside_next.neg1 = n1[NUM_W-1] ^ sq_side.a[COEF_W-1];
        dside_next.neg2 = n2[NUM_W-1] ^ sq_side.a[COEF_W-1];
        dside_next.dvs  = sq_side.a[COEF_W-1] ? DVS_W'(-sq_side.a) : DVS_W'(sq_side.a);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            nm_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd1_reg  <= {m1[NUM_W-2:0], 7'd0};
            dvd2_reg  <= {m2[NUM_W-2:0], 7'd0};
            dside_reg <= dside_next;
        end
    end

    qrs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nm_valid_reg),
        .dvd1      (dvd1_reg),
        .dvd2      (dvd2_reg),
        .in_side   (dside_reg),
        .out_valid (dv_valid),
        .quo1      (quo1),
        .quo2      (quo2),
        .out_side  (dv_side)
    );

    // sign and clip
    assign s1 = dv_side.neg1 ? -$signed({1'b0, quo1}) : $signed({1'b0, quo1});
    assign s2 = dv_side.neg2 ? -$signed({1'b0, quo2}) : $signed({1'b0, quo2});
    assign sat1 = (s1 > QS_W'(VAL_MAX)) || (s1 < QS_W'(VAL_MIN));
    assign sat2 = (s2 > QS_W'(VAL_MAX)) || (s2 < QS_W'(VAL_MIN));

    always_comb
    begin
        res_next.kind = dv_side.kind;
        if (dv_side.kind == KIND_DEGEN)
        begin
            res_next.v1  = '0;
            res_next.v2  = '0;
            res_next.sat = 1'b0;
        end
        else
        begin
            res_next.v1  = sat1 ? (s1[QS_W-1] ? VAL_MIN : VAL_MAX) : s1[VAL_W-1:0];
            res_next.v2  = sat2 ? (s2[QS_W-1] ? VAL_MIN : VAL_MAX) : s2[VAL_W-1:0];
            res_next.sat = sat1 || sat2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (m_tready)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (dv_valid)
            begin
                if (out_valid_reg && !m_tready)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (dv_valid)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                out_reg <= res_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.v2, out_reg.v1};
    assign m_tuser  = {out_reg.sat, out_reg.kind};

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_DEGEN)
            |-> (out_reg.v1 == '0 && out_reg.v2 == '0 && !out_reg.sat))
        else $error("degenerate result carries nonzero values");

    a_double_same: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_DOUBLE) |-> out_reg.v1 == out_reg.v2)
        else $error("double root values differ");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.sat)
            |-> (out_reg.v1 == VAL_MAX || out_reg.v1 == VAL_MIN
                 || out_reg.v2 == VAL_MAX || out_reg.v2 == VAL_MIN))
        else $error("saturation flag without a clipped value");

endmodule

>>> sv/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// Two stages: coefficient products, then discriminant, kind and radicand.
// ----------------------------------------------------------------------------
module qrs_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [qrs_pkg::COEF_W-1:0] a,
    input  logic signed [qrs_pkg::COEF_W-1:0] b,
    input  logic signed [qrs_pkg::COEF_W-1:0] c,
    output logic                             out_valid,
    output logic [qrs_pkg::RAD_W-1:0]        rad,
    output qrs_pkg::sq_side_t                side
);
    import qrs_pkg::*;

    logic                      v1_reg;
    logic signed [COEF_W-1:0]  a1_reg;
    logic signed [COEF_W-1:0]  b1_reg;
    logic signed [2*COEF_W-1:0] bb_reg;
    logic signed [2*COEF_W-1:0] ac_reg;
    logic signed [2*COEF_W-1:0] bb_next;
    logic signed [2*COEF_W-1:0] ac_next;

    logic                      v2_reg;
    logic [RAD_W-1:0]          rad_reg;
    sq_side_t                  side_reg;
    logic signed [MAG_W:0]     disc;
    logic [MAG_W-1:0]          mag;
    sq_side_t                  side_next;

    assign bb_next = b * b;
    assign ac_next = a * c;

    assign disc = (MAG_W+1)'(bb_reg) - ((MAG_W+1)'(ac_reg) <<< 2);
    assign mag  = disc[MAG_W] ? MAG_W'(-disc) : disc[MAG_W-1:0];

    always_comb
    begin
        side_next.a  = a1_reg;
        side_next.nb = -(NB_W'(b1_reg) <<< 8);
        if (a1_reg == '0)
        begin
            side_next.kind = KIND_DEGEN;
        end
        else if (disc[MAG_W])
        begin
            side_next.kind = KIND_COMPLEX;
        end
        else if (disc == '0)
        begin
            side_next.kind = KIND_DOUBLE;
        end
        else
        begin
            side_next.kind = KIND_DISTINCT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg   <= a;
            b1_reg   <= b;
            bb_reg   <= bb_next;
            ac_reg   <= ac_next;
            rad_reg  <= {mag, 16'd0};
            side_reg <= side_next;
        end
    end

    assign out_valid = v2_reg;
    assign rad       = rad_reg;
    assign side      = side_reg;

endmodule

>>> sv/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [qrs_pkg::RAD_W-1:0]  rad,
    input  qrs_pkg::sq_side_t          in_side,
    output logic                       out_valid,
    output logic [qrs_pkg::ROOT_W-1:0] root,
    output qrs_pkg::sq_side_t          out_side
);
    import qrs_pkg::*;

    // element 0 is the input, element k+1 the register after stage k
    logic [RAD_W-1:0]  rad_w  [ROOT_W+1];
    logic [REM_W-1:0]  rem_w  [ROOT_W+1];
    logic [ROOT_W-1:0] q_w    [ROOT_W+1];
    sq_side_t          side_w [ROOT_W+1];
    logic              v_w    [ROOT_W+1];

    assign rad_w[0]  = rad;
    assign rem_w[0]  = '0;
    assign q_w[0]    = '0;
    assign side_w[0] = in_side;
    assign v_w[0]    = in_valid;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        logic             ge;

        assign cur   = {rem_w[k][REM_W-3:0], rad_w[k][RAD_W-1:RAD_W-2]};
        assign trial = REM_W'({q_w[k], 2'b01});
        assign ge    = cur >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_w[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_w[k+1] <= v_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_w[k+1]  <= rad_w[k] << 2;
                rem_w[k+1]  <= ge ? cur - trial : cur;
                q_w[k+1]    <= {q_w[k][ROOT_W-2:0], ge};
                side_w[k+1] <= side_w[k];
            end
        end
    end

    assign out_valid = v_w[ROOT_W];
    assign root      = q_w[ROOT_W];
    assign out_side  = side_w[ROOT_W];

endmodule

>>> sv/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [qrs_pkg::DVD_W-1:0] dvd1,
    input  logic [qrs_pkg::DVD_W-1:0] dvd2,
    input  qrs_pkg::dv_side_t         in_side,
    output logic                      out_valid,
    output logic [qrs_pkg::DVD_W-1:0] quo1,
    output logic [qrs_pkg::DVD_W-1:0] quo2,
    output qrs_pkg::dv_side_t         out_side
);
    import qrs_pkg::*;

    // dividend shifts out the top while quotient bits shift in below
    logic [DVD_W-1:0] dq_w   [2][DVD_W+1];
    logic [DVS_W-1:0] rem_w  [2][DVD_W+1];
    dv_side_t         side_w [DVD_W+1];
    logic             v_w    [DVD_W+1];

    assign dq_w[0][0]  = dvd1;
    assign dq_w[1][0]  = dvd2;
    assign rem_w[0][0] = '0;
    assign rem_w[1][0] = '0;
    assign side_w[0]   = in_side;
    assign v_w[0]      = in_valid;

    for (genvar k = 0; k < DVD_W; k++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_w[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_w[k+1] <= v_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_w[k+1] <= side_w[k];
            end
        end

        for (genvar j = 0; j < 2; j++)
        begin : g_lane
            logic [DVS_W:0] cur;
            logic           ge;

            assign cur = {rem_w[j][k], dq_w[j][k][DVD_W-1]};
            assign ge  = cur >= {1'b0, side_w[k].dvs};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_w[j][k+1] <= ge ? DVS_W'(cur - {1'b0, side_w[k].dvs})
                                        : cur[DVS_W-1:0];
                    dq_w[j][k+1]  <= {dq_w[j][k][DVD_W-2:0], ge};
                end
            end
        end
    end

    assign out_valid = v_w[DVD_W];
    assign quo1      = dq_w[0][DVD_W];
    assign quo2      = dq_w[1][DVD_W];
    assign out_side  = side_w[DVD_W];

endmodule
